/* hdl/gcs_pkg.sv */
`default_nettype none

package gcs_pkg;

  localparam int KEY_W = 8;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    RS_OK        = 2'd0,
    RS_NOT_READY = 2'd1,
    RS_RANGE     = 2'd2
  } rd_status_t;

endpackage

`default_nettype wire

/* hdl/gcs_hist_ram.sv */
`default_nettype none

module gcs_hist_ram #(
  parameter int DEPTH = 257,
  parameter int AW    = 9,
  parameter int DW    = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/gcs_item_ram.sv */
`default_nettype none

module gcs_item_ram
  import gcs_pkg::*;
#(
  parameter int MAX_ITEMS    = 1024,
  parameter int PAYLOAD_BITS = 32,
  parameter int IA_W         = 10
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic                    wsel,
  input  wire logic [IA_W-1:0]         widx,
  input  wire logic [KEY_W-1:0]        wkey,
  input  wire logic [PAYLOAD_BITS-1:0] wpay,
  input  wire logic                    re,
  input  wire logic                    rsel,
  input  wire logic [IA_W-1:0]         ridx,
  output logic      [KEY_W-1:0]        rkey,
  output logic      [PAYLOAD_BITS-1:0] rpay
);

  // lower half holds items in load order, upper half in sorted order
  localparam int DEPTH = 2 * MAX_ITEMS;
  localparam int MA_W  = $clog2(DEPTH);
  localparam int DW    = KEY_W + PAYLOAD_BITS;

  logic [DW-1:0]   mem [DEPTH];
  logic [MA_W-1:0] waddr;
  logic [MA_W-1:0] raddr;
  logic [DW-1:0]   rdata;

  assign waddr = MA_W'(widx) + (wsel ? MA_W'(MAX_ITEMS) : MA_W'(0));
  assign raddr = MA_W'(ridx) + (rsel ? MA_W'(MAX_ITEMS) : MA_W'(0));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wkey, wpay};
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  assign rkey = rdata[DW-1:PAYLOAD_BITS];
  assign rpay = rdata[PAYLOAD_BITS-1:0];

endmodule

`default_nettype wire

/* hdl/group_counting_sort_top.sv */
`default_nettype none

// channel   direction  handshake             payload
// in_       input      in_valid / in_ready   opcode, group_key, payload, last_item, read_index
// out_      output     out_valid / out_ready sorted_key, sorted_payload, group_start,
//                                            item_total, overflow_seen, read_status
//
// a load is a histogram read-modify-write; a dropped load is not stored and sets overflow
// the first load of a new batch first clears the histogram, then issues its read
// the last load then runs the prefix pass and scatters each item into sorted order
// a read issues its RAM reads and its result goes to an output register
// after reset the histogram is cleared with in_ready low
// a read finished while the output register is full waits in its data stage
module group_counting_sort_top
  import gcs_pkg::*;
#(
  parameter int MAX_ITEMS    = 1024,
  parameter int NUM_GROUPS   = 256,
  parameter int PAYLOAD_BITS = 32,
  localparam int CNT_W       = $clog2(MAX_ITEMS + 1),
  localparam int HA_W        = $clog2(NUM_GROUPS + 1),
  localparam int RD_W        = (CNT_W > HA_W) ? CNT_W : HA_W
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    in_opcode,
  input  wire logic [KEY_W-1:0]        in_group_key,
  input  wire logic [PAYLOAD_BITS-1:0] in_payload,
  input  wire logic                    in_last_item,
  input  wire logic [RD_W-1:0]         in_read_index,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic      [KEY_W-1:0]        out_sorted_key,
  output logic      [PAYLOAD_BITS-1:0] out_sorted_payload,
  output logic      [CNT_W-1:0]        out_group_start,
  output logic      [CNT_W-1:0]        out_item_total,
  output logic                         out_overflow_seen,
  output logic      [1:0]              out_read_status
);

  localparam int IA_W  = $clog2(MAX_ITEMS);
  localparam int HD    = NUM_GROUPS + 1;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_CLR      = 10'b00_0000_0010,
    S_LD_RD    = 10'b00_0000_0100,
    S_LD_WR    = 10'b00_0000_1000,
    S_PFX      = 10'b00_0001_0000,
    S_PFX_TAIL = 10'b00_0010_0000,
    S_SC_START = 10'b00_0100_0000,
    S_SC_KEY   = 10'b00_1000_0000,
    S_SC_WR    = 10'b01_0000_0000,
    S_RD_DATA  = 10'b10_0000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [HA_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [HA_W-1:0] pcnt_r, pcnt_nxt;
  logic            p_vld_r, p_vld_nxt;
  logic [HA_W-1:0] p_addr_r, p_addr_nxt;
  logic [CNT_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] sc_i_r, sc_i_nxt;
  logic [CNT_W-1:0] loaded_r, loaded_nxt;
  logic            sort_done_r, sort_done_nxt;
  logic            ovf_r, ovf_nxt;
  logic            pend_ld_r, pend_ld_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic [KEY_W-1:0]        key_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic                    last_r;
  logic                    rd_nr_r;
  logic                    rd_oor_r;

  logic [KEY_W-1:0]        o_key_r;
  logic [PAYLOAD_BITS-1:0] o_pay_r;
  logic [CNT_W-1:0]        o_start_r;
  logic [CNT_W-1:0]        o_total_r;
  logic                    o_ovf_r;
  rd_status_t              o_status_r;
  logic                    out_load;

  logic                    in_fire;
  logic [KEY_W-1:0]        in_key_sat;
  logic [HA_W-1:0]         rd_grp;
  logic                    rd_oor;

  logic                    hist_we, hist_re;
  logic [HA_W-1:0]         hist_waddr, hist_raddr;
  logic [CNT_W-1:0]        hist_wdata, hist_rdata;

  logic                    item_we, item_wsel, item_re, item_rsel;
  logic [IA_W-1:0]         item_widx, item_ridx;
  logic [KEY_W-1:0]        item_wkey, item_rkey;
  logic [PAYLOAD_BITS-1:0] item_wpay, item_rpay;

  gcs_hist_ram #(
    .DEPTH (HD),
    .AW    (HA_W),
    .DW    (CNT_W)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .re    (hist_re),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  gcs_item_ram #(
    .MAX_ITEMS    (MAX_ITEMS),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .IA_W         (IA_W)
  ) u_items (
    .clk  (clk),
    .we   (item_we),
    .wsel (item_wsel),
    .widx (item_widx),
    .wkey (item_wkey),
    .wpay (item_wpay),
    .re   (item_re),
    .rsel (item_rsel),
    .ridx (item_ridx),
    .rkey (item_rkey),
    .rpay (item_rpay)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign in_key_sat = (32'(in_group_key) >= NUM_GROUPS) ? KEY_W'(NUM_GROUPS - 1) : in_group_key;
  assign rd_grp     = (in_read_index > RD_W'(NUM_GROUPS)) ? HA_W'(NUM_GROUPS)
                                                           : HA_W'(in_read_index);
  assign rd_oor     = (in_read_index >= RD_W'(loaded_r));

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    pcnt_nxt      = pcnt_r;
    p_vld_nxt     = 1'b0;
    p_addr_nxt    = p_addr_r;
    sum_nxt       = sum_r;
    sc_i_nxt      = sc_i_r;
    loaded_nxt    = loaded_r;
    sort_done_nxt = sort_done_r;
    ovf_nxt       = ovf_r;
    pend_ld_nxt   = pend_ld_r;
    out_load      = 1'b0;

    hist_we    = 1'b0;
    hist_waddr = '0;
    hist_wdata = '0;
    hist_re    = 1'b0;
    hist_raddr = '0;
    item_we    = 1'b0;
    item_wsel  = 1'b0;
    item_widx  = loaded_r[IA_W-1:0];
    item_wkey  = in_key_sat;
    item_wpay  = in_payload;
    item_re    = 1'b0;
    item_rsel  = 1'b0;
    item_ridx  = '0;

    // prefix pass write-back, one group behind its read
    if (p_vld_r) begin
      hist_we    = 1'b1;
      hist_waddr = p_addr_r;
      hist_wdata = sum_r;
      sum_nxt    = sum_r + hist_rdata;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (opcode_t'(in_opcode) == OP_LOAD) begin
            if (sort_done_r) begin
              sort_done_nxt = 1'b0;
              loaded_nxt    = '0;
              ovf_nxt       = 1'b0;
              pend_ld_nxt   = 1'b1;
              clr_cnt_nxt   = '0;
              state_nxt     = S_CLR;
            end else if (loaded_r == CNT_W'(MAX_ITEMS)) begin
              ovf_nxt = 1'b1;
              if (in_last_item) begin
                pcnt_nxt  = HA_W'(1);
                sum_nxt   = '0;
                state_nxt = S_PFX;
              end
            end else begin
              hist_re    = 1'b1;
              hist_raddr = HA_W'(in_key_sat) + HA_W'(1);
              item_we    = 1'b1;
              state_nxt  = S_LD_WR;
            end
          end else begin
            if (sort_done_r) begin
              hist_re    = 1'b1;
              hist_raddr = rd_grp;
              item_re    = 1'b1;
              item_rsel  = 1'b1;
              item_ridx  = in_read_index[IA_W-1:0];
            end
            state_nxt = S_RD_DATA;
          end
        end
      end
      S_CLR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_cnt_r;
        hist_wdata = '0;
        if (clr_cnt_r == HA_W'(NUM_GROUPS)) begin
          pend_ld_nxt = 1'b0;
          state_nxt   = pend_ld_r ? S_LD_RD : S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + HA_W'(1);
        end
      end
      S_LD_RD: begin
        hist_re    = 1'b1;
        hist_raddr = HA_W'(key_r) + HA_W'(1);
        item_we    = 1'b1;
        item_wkey  = key_r;
        item_wpay  = pay_r;
        state_nxt  = S_LD_WR;
      end
      S_LD_WR: begin
        hist_we    = 1'b1;
        hist_waddr = HA_W'(key_r) + HA_W'(1);
        hist_wdata = hist_rdata + CNT_W'(1);
        loaded_nxt = loaded_r + CNT_W'(1);
        if (last_r) begin
          pcnt_nxt  = HA_W'(1);
          sum_nxt   = '0;
          state_nxt = S_PFX;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PFX: begin
        hist_re    = 1'b1;
        hist_raddr = pcnt_r;
        p_vld_nxt  = 1'b1;
        p_addr_nxt = pcnt_r;
        if (pcnt_r == HA_W'(NUM_GROUPS)) begin
          state_nxt = S_PFX_TAIL;
        end else begin
          pcnt_nxt = pcnt_r + HA_W'(1);
        end
      end
      S_PFX_TAIL: begin
        state_nxt = S_SC_START;
      end
      S_SC_START: begin
        if (loaded_r == '0) begin
          sort_done_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          item_re   = 1'b1;
          item_ridx = '0;
          sc_i_nxt  = '0;
          state_nxt = S_SC_KEY;
        end
      end
      S_SC_KEY: begin
        hist_re    = 1'b1;
        hist_raddr = HA_W'(item_rkey) + HA_W'(1);
        state_nxt  = S_SC_WR;
      end
      S_SC_WR: begin
        hist_we    = 1'b1;
        hist_waddr = HA_W'(item_rkey) + HA_W'(1);
        hist_wdata = hist_rdata + CNT_W'(1);
        item_we    = 1'b1;
        item_wsel  = 1'b1;
        item_widx  = hist_rdata[IA_W-1:0];
        item_wkey  = item_rkey;
        item_wpay  = item_rpay;
        sc_i_nxt   = sc_i_r + CNT_W'(1);
        if (sc_i_r + CNT_W'(1) == loaded_r) begin
          sort_done_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          item_re   = 1'b1;
          item_ridx = sc_i_nxt[IA_W-1:0];
          state_nxt = S_SC_KEY;
        end
      end
      S_RD_DATA: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      pcnt_r      <= '0;
      p_vld_r     <= 1'b0;
      p_addr_r    <= '0;
      sum_r       <= '0;
      sc_i_r      <= '0;
      loaded_r    <= '0;
      sort_done_r <= 1'b0;
      ovf_r       <= 1'b0;
      pend_ld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pcnt_r      <= pcnt_nxt;
      p_vld_r     <= p_vld_nxt;
      p_addr_r    <= p_addr_nxt;
      sum_r       <= sum_nxt;
      sc_i_r      <= sc_i_nxt;
      loaded_r    <= loaded_nxt;
      sort_done_r <= sort_done_nxt;
      ovf_r       <= ovf_nxt;
      pend_ld_r   <= pend_ld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // captured transaction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r    <= in_key_sat;
      pay_r    <= in_payload;
      last_r   <= in_last_item;
      rd_nr_r  <= !sort_done_r;
      rd_oor_r <= rd_oor;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_total_r <= loaded_r;
      o_ovf_r   <= ovf_r;
      if (rd_nr_r) begin
        o_key_r    <= '0;
        o_pay_r    <= '0;
        o_start_r  <= '0;
        o_status_r <= RS_NOT_READY;
      end else if (rd_oor_r) begin
        o_key_r    <= '0;
        o_pay_r    <= '0;
        o_start_r  <= hist_rdata;
        o_status_r <= RS_RANGE;
      end else begin
        o_key_r    <= item_rkey;
        o_pay_r    <= item_rpay;
        o_start_r  <= hist_rdata;
        o_status_r <= RS_OK;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sorted_key     = o_key_r;
  assign out_sorted_payload = o_pay_r;
  assign out_group_start    = o_start_r;
  assign out_item_total     = o_total_r;
  assign out_overflow_seen  = o_ovf_r;
  assign out_read_status    = o_status_r;

  a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r <= CNT_W'(MAX_ITEMS))
    else $error("loaded count beyond capacity");

  a_scatter_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SC_WR) |-> (sc_i_r < loaded_r))
    else $error("scatter index past loaded count");

  a_new_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && opcode_t'(in_opcode) == OP_LOAD && sort_done_r) |=> (state_r == S_CLR))
    else $error("new batch did not start a histogram clear");

  a_start_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_group_start <= out_item_total))
    else $error("group start beyond item total");

endmodule

`default_nettype wire
